@@ sv/limit_order_matcher_assert.svh @@
// Assertion macros used by the order matcher datapath.
`ifndef LIMIT_ORDER_MATCHER_ASSERT_SVH
`define LIMIT_ORDER_MATCHER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define LOM_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define LOM_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

`endif

@@ sv/lom_pkg.sv @@
// Shared types, codes and constants of the limit order matcher.
package lom_pkg;

    localparam int BOOK_DEPTH_DEF      = 32;
    localparam int NUM_INSTRUMENTS_DEF = 5;
    localparam int MAX_MATCHES         = 31;
    localparam int QW                  = 11;
    localparam logic [QW-1:0] MIN_QTY_RESET = 11'd10;
    localparam logic [QW-1:0] MAX_QTY_RESET = 11'd1000;

    // Reciprocal of the lot size of ten, exact for all 16-bit quantities.
    localparam logic [15:0] LOT_RECIP = 16'd52429;
    localparam int          LOT_SHIFT = 19;

    localparam logic REG_MIN_QTY = 1'b0;
    localparam logic REG_MAX_QTY = 1'b1;

    localparam logic [1:0] SIDE_BUY  = 2'd1;
    localparam logic [1:0] SIDE_SELL = 2'd2;

    typedef enum logic [1:0] {AGG_NEW, AGG_REJECT, AGG_FILL, AGG_PARTIAL} agg_status_t;

    typedef enum logic [2:0] {
        RSN_NONE, RSN_FIELDS, RSN_INSTRUMENT, RSN_SIDE, RSN_PRICE, RSN_SIZE, RSN_BOOK_FULL
    } reason_t;

    typedef enum logic [1:0] {RST_NONE, RST_FILLED, RST_PARTIAL} rest_status_t;

    typedef enum logic [1:0] {ORD_NEW, ORD_REJ_VALID, ORD_REJ_FULL} order_rpt_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CHECK, ST_SCAN_INIT, ST_SCAN, ST_DECIDE, ST_REMOVE,
        ST_SHIFT_RD, ST_SHIFT_WR, ST_FINISH, ST_END_REST, ST_END_REJECT
    } state_t;

    typedef struct packed {
        logic signed [31:0] price;
        logic [QW-1:0]      remaining;
        logic [31:0]        client_tag;
        logic [31:0]        order_number;
    } entry_t;

    typedef struct packed {
        logic signed [31:0] price;
        logic [QW-1:0]      qty;
        agg_status_t        agg;
        logic [31:0]        rtag;
        logic [31:0]        rnum;
        rest_status_t       rstat;
        logic               last;
    } pend_t;

    typedef struct packed {
        logic       accept;
        logic       clear_match;
        logic       scan_start;
        logic       scan_step;
        logic       do_match;
        logic       push_pend;
        logic       flush_last;
        logic       push_order;
        order_rpt_t order_kind;
        logic       shift_rd;
        logic       shift_wr;
        logic       dec_opp;
        logic       rest;
        logic       sel_own;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic reason_nz;
        logic qty_zero;
        logic scan_done;
        logic found;
        logic crosses;
        logic capped;
        logic rq_zero;
        logic rem_after_zero;
        logic rem_zero;
        logic shift_done;
        logic own_full;
        logic pend_valid;
    } sts_t;

endpackage

@@ sv/lom_ctrl.sv @@
// Controller state machine of the limit order matcher.
module lom_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  lom_pkg::sts_t   sts,
    output lom_pkg::cmd_t   cmd,
    output logic            idle
);

    lom_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lom_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = lom_pkg::ST_CHECK;
                end
            end
            lom_pkg::ST_CHECK:
            begin
                if (sts.reason_nz || sts.qty_zero)
                begin
                    if (sts.out_free)
                    begin
                        state_next = lom_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    state_next = lom_pkg::ST_SCAN_INIT;
                end
            end
            lom_pkg::ST_SCAN_INIT: state_next = lom_pkg::ST_SCAN;
            lom_pkg::ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = lom_pkg::ST_DECIDE;
                end
            end
            lom_pkg::ST_DECIDE:
            begin
                priority if (!sts.found || !sts.crosses)
                begin
                    state_next = lom_pkg::ST_END_REST;
                end
                else if (sts.capped)
                begin
                    state_next = lom_pkg::ST_END_REJECT;
                end
                else if (sts.pend_valid && !sts.out_free)
                begin
                    state_next = lom_pkg::ST_DECIDE;
                end
                else if (sts.rq_zero)
                begin
                    state_next = lom_pkg::ST_REMOVE;
                end
                else if (sts.rem_after_zero)
                begin
                    state_next = lom_pkg::ST_FINISH;
                end
                else
                begin
                    state_next = lom_pkg::ST_SCAN_INIT;
                end
            end
            lom_pkg::ST_REMOVE:
            begin
                if (sts.shift_done)
                begin
                    state_next = sts.rem_zero ? lom_pkg::ST_FINISH : lom_pkg::ST_SCAN_INIT;
                end
                else
                begin
                    state_next = lom_pkg::ST_SHIFT_RD;
                end
            end
            lom_pkg::ST_SHIFT_RD: state_next = lom_pkg::ST_SHIFT_WR;
            lom_pkg::ST_SHIFT_WR: state_next = lom_pkg::ST_REMOVE;
            lom_pkg::ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    state_next = lom_pkg::ST_IDLE;
                end
            end
            lom_pkg::ST_END_REST:
            begin
                if (sts.own_full)
                begin
                    state_next = lom_pkg::ST_END_REJECT;
                end
                else if (sts.out_free)
                begin
                    state_next = lom_pkg::ST_IDLE;
                end
            end
            lom_pkg::ST_END_REJECT:
            begin
                if (sts.out_free && !sts.pend_valid)
                begin
                    state_next = lom_pkg::ST_IDLE;
                end
            end
            default: state_next = lom_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.order_kind = lom_pkg::ORD_NEW;
        idle = 1'b0;
        unique case (state_reg)
            lom_pkg::ST_IDLE:
            begin
                idle = 1'b1;
                cmd.accept = in_valid;
            end
            lom_pkg::ST_CHECK:
            begin
                if (sts.reason_nz)
                begin
                    cmd.push_order = sts.out_free;
                    cmd.order_kind = lom_pkg::ORD_REJ_VALID;
                end
                else if (sts.qty_zero)
                begin
                    cmd.push_order = sts.out_free;
                end
                else
                begin
                    cmd.clear_match = 1'b1;
                end
            end
            lom_pkg::ST_SCAN_INIT: cmd.scan_start = 1'b1;
            lom_pkg::ST_SCAN:      cmd.scan_step = 1'b1;
            lom_pkg::ST_DECIDE:
            begin
                if (sts.found && sts.crosses && !sts.capped
                    && (!sts.pend_valid || sts.out_free))
                begin
                    cmd.do_match  = 1'b1;
                    cmd.push_pend = sts.pend_valid;
                end
            end
            lom_pkg::ST_REMOVE:   cmd.dec_opp  = sts.shift_done;
            lom_pkg::ST_SHIFT_RD: cmd.shift_rd = 1'b1;
            lom_pkg::ST_SHIFT_WR: cmd.shift_wr = 1'b1;
            lom_pkg::ST_FINISH:
            begin
                cmd.push_pend  = sts.out_free;
                cmd.flush_last = 1'b1;
            end
            lom_pkg::ST_END_REST:
            begin
                cmd.sel_own = 1'b1;
                if (!sts.own_full && sts.out_free)
                begin
                    cmd.rest       = 1'b1;
                    cmd.push_pend  = sts.pend_valid;
                    cmd.flush_last = 1'b1;
                    cmd.push_order = !sts.pend_valid;
                end
            end
            lom_pkg::ST_END_REJECT:
            begin
                if (sts.out_free)
                begin
                    cmd.push_pend  = sts.pend_valid;
                    cmd.push_order = !sts.pend_valid;
                    cmd.order_kind = lom_pkg::ORD_REJ_FULL;
                end
            end
            default: idle = 1'b0;
        endcase
    end

endmodule

@@ sv/lom_datapath.sv @@
// Datapath of the limit order matcher: order registers, book memory, counts and output.
`include "limit_order_matcher_assert.svh"

module lom_datapath #(
    parameter int BOOK_DEPTH      = lom_pkg::BOOK_DEPTH_DEF,
    parameter int NUM_INSTRUMENTS = lom_pkg::NUM_INSTRUMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lom_pkg::cmd_t             cmd,
    output lom_pkg::sts_t             sts,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [lom_pkg::QW-1:0]    cfg_data,
    input  logic [31:0]               client_tag,
    input  logic [2:0]                instrument,
    input  logic [1:0]                side,
    input  logic signed [31:0]        limit_price,
    input  logic [15:0]               quantity,
    input  logic                      fields_complete,
    input  logic                      out_stall,
    output logic                      out_valid,
    output logic [31:0]               client_tag_out,
    output logic [31:0]               order_number,
    output logic [2:0]                instrument_out,
    output logic [1:0]                side_out,
    output logic signed [31:0]        report_price,
    output logic [15:0]               report_quantity,
    output logic [1:0]                aggressor_status,
    output logic [2:0]                reject_reason,
    output logic [31:0]               resting_client_tag,
    output logic [31:0]               resting_order_number,
    output logic [1:0]                resting_status,
    output logic                      last_report
);

    localparam int NB = 2 * NUM_INSTRUMENTS;
    localparam int BW = $clog2(NB);
    localparam int IW = (BOOK_DEPTH > 1) ? $clog2(BOOK_DEPTH) : 1;
    localparam int CW = $clog2(BOOK_DEPTH + 1);
    localparam int AW = BW + IW;
    localparam int QW = lom_pkg::QW;

    // Configuration registers.
    logic [QW-1:0] min_qty_reg, max_qty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_qty_reg <= lom_pkg::MIN_QTY_RESET;
            max_qty_reg <= lom_pkg::MAX_QTY_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lom_pkg::REG_MIN_QTY)
            begin
                min_qty_reg <= cfg_data;
            end
            else
            begin
                max_qty_reg <= cfg_data;
            end
        end
    end

    // The incoming order and its sequence number.
    logic [31:0]        num_reg;
    logic [31:0]        ord_tag_reg, ord_num_reg;
    logic [2:0]         ord_inst_reg;
    logic [1:0]         ord_side_reg;
    logic signed [31:0] ord_price_reg;
    logic [15:0]        ord_qty_reg;
    logic               ord_complete_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= 32'd1;
        end
        else if (cmd.accept)
        begin
            num_reg <= num_reg + 32'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            ord_tag_reg      <= client_tag;
            ord_num_reg      <= num_reg;
            ord_inst_reg     <= instrument;
            ord_side_reg     <= side;
            ord_price_reg    <= limit_price;
            ord_qty_reg      <= quantity;
            ord_complete_reg <= fields_complete;
        end
    end

    // Validation. The lot check multiplies by the reciprocal of ten.
    logic [31:0]       lot_prod;
    logic [12:0]       lot_quot;
    logic [16:0]       lot_back;
    lom_pkg::reason_t  reason;
    logic              is_buy;

    assign lot_prod = ord_qty_reg * lom_pkg::LOT_RECIP;
    assign lot_quot = lot_prod[31:lom_pkg::LOT_SHIFT];
    assign lot_back = {1'b0, lot_quot, 3'b000} + {3'b000, lot_quot, 1'b0};
    assign is_buy   = (ord_side_reg == lom_pkg::SIDE_BUY);

    always_comb
    begin
        priority if (!ord_complete_reg)
        begin
            reason = lom_pkg::RSN_FIELDS;
        end
        else if ({1'b0, ord_inst_reg} >= 4'(NUM_INSTRUMENTS))
        begin
            reason = lom_pkg::RSN_INSTRUMENT;
        end
        else if (ord_side_reg != lom_pkg::SIDE_BUY && ord_side_reg != lom_pkg::SIDE_SELL)
        begin
            reason = lom_pkg::RSN_SIDE;
        end
        else if (ord_price_reg <= 32'sd0)
        begin
            reason = lom_pkg::RSN_PRICE;
        end
        else if (lot_back != {1'b0, ord_qty_reg}
                 || ord_qty_reg < {5'd0, min_qty_reg}
                 || ord_qty_reg > {5'd0, max_qty_reg})
        begin
            reason = lom_pkg::RSN_SIZE;
        end
        else
        begin
            reason = lom_pkg::RSN_NONE;
        end
    end

    // Book selection: two books per instrument, buys then sells.
    logic [BW-1:0] book_own, book_opp;
    assign book_own = BW'({ord_inst_reg, ord_side_reg == lom_pkg::SIDE_SELL});
    assign book_opp = BW'({ord_inst_reg, ord_side_reg == lom_pkg::SIDE_BUY});

    logic [CW-1:0] count_reg [NB];
    logic [CW-1:0] cnt_sel;
    assign cnt_sel = count_reg[cmd.sel_own ? book_own : book_opp];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < NB; b++)
            begin
                count_reg[b] <= '0;
            end
        end
        else if (cmd.dec_opp)
        begin
            count_reg[book_opp] <= count_reg[book_opp] - CW'(1);
        end
        else if (cmd.rest)
        begin
            count_reg[book_own] <= count_reg[book_own] + CW'(1);
        end
    end

    // Book memory, one entry per word, registered read.
    lom_pkg::entry_t mem [2**AW];
    lom_pkg::entry_t mem_q;
    logic            rd_en, wr_en;
    logic [AW-1:0]   rd_addr, wr_addr;
    lom_pkg::entry_t wr_data;

    // Scan and match state.
    logic [CW-1:0]      issue_reg;
    logic               rdv_reg;
    logic [IW-1:0]      rd_idx_reg;
    logic               found_reg;
    logic [IW-1:0]      best_idx_reg;
    lom_pkg::entry_t    best_reg;
    logic [QW-1:0]      rem_reg;
    logic [4:0]         n_reg;
    logic [IW-1:0]      ptr_reg;
    logic [CW-1:0]      ptr_plus;
    lom_pkg::pend_t     pend_reg;
    logic               pend_valid_reg;
    logic               issue_more, better;
    logic [QW-1:0]      ex, rem_after, rq;

    assign ptr_plus   = CW'(ptr_reg) + CW'(1);
    assign issue_more = issue_reg < cnt_sel;
    assign better     = !found_reg || (is_buy ? (mem_q.price < best_reg.price)
                                              : (mem_q.price > best_reg.price));
    assign ex         = (rem_reg < best_reg.remaining) ? rem_reg : best_reg.remaining;
    assign rem_after  = rem_reg - ex;
    assign rq         = best_reg.remaining - ex;

    always_comb
    begin
        rd_en   = (cmd.scan_step && issue_more) || cmd.shift_rd;
        rd_addr = cmd.shift_rd ? {book_opp, ptr_plus[IW-1:0]} : {book_opp, issue_reg[IW-1:0]};
        wr_en   = 1'b0;
        wr_addr = {book_opp, ptr_reg};
        wr_data = mem_q;
        if (cmd.do_match && rq != '0)
        begin
            wr_en             = 1'b1;
            wr_addr           = {book_opp, best_idx_reg};
            wr_data           = best_reg;
            wr_data.remaining = rq;
        end
        else if (cmd.shift_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.rest)
        begin
            wr_en                = 1'b1;
            wr_addr              = {book_own, cnt_sel[IW-1:0]};
            wr_data.price        = ord_price_reg;
            wr_data.remaining    = rem_reg;
            wr_data.client_tag   = ord_tag_reg;
            wr_data.order_number = ord_num_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            mem_q <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rdv_reg        <= 1'b0;
            found_reg      <= 1'b0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clear_match)
            begin
                n_reg          <= '0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.scan_start)
            begin
                rdv_reg   <= 1'b0;
                found_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                rdv_reg <= issue_more;
                if (rdv_reg && better)
                begin
                    found_reg <= 1'b1;
                end
            end
            if (cmd.push_pend)
            begin
                pend_valid_reg <= 1'b0;
            end
            if (cmd.do_match)
            begin
                n_reg          <= n_reg + 5'd1;
                pend_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear_match)
        begin
            rem_reg <= ord_qty_reg[QW-1:0];
        end
        if (cmd.scan_start)
        begin
            issue_reg <= '0;
        end
        if (cmd.scan_step)
        begin
            if (issue_more)
            begin
                issue_reg  <= issue_reg + CW'(1);
                rd_idx_reg <= issue_reg[IW-1:0];
            end
            if (rdv_reg && better)
            begin
                best_reg     <= mem_q;
                best_idx_reg <= rd_idx_reg;
            end
        end
        if (cmd.do_match)
        begin
            rem_reg        <= rem_after;
            ptr_reg        <= best_idx_reg;
            pend_reg.price <= best_reg.price;
            pend_reg.qty   <= ex;
            pend_reg.agg   <= (rem_after == '0) ? lom_pkg::AGG_FILL : lom_pkg::AGG_PARTIAL;
            pend_reg.rtag  <= best_reg.client_tag;
            pend_reg.rnum  <= best_reg.order_number;
            pend_reg.rstat <= (rq == '0) ? lom_pkg::RST_FILLED : lom_pkg::RST_PARTIAL;
            pend_reg.last  <= (rem_after == '0);
        end
        if (cmd.shift_wr)
        begin
            ptr_reg <= ptr_plus[IW-1:0];
        end
    end

    // Output register.
    logic out_valid_reg;
    logic push;

    assign push = cmd.push_pend || cmd.push_order;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            client_tag_out <= ord_tag_reg;
            order_number   <= ord_num_reg;
            instrument_out <= ord_inst_reg;
            side_out       <= ord_side_reg;
            if (cmd.push_pend)
            begin
                report_price         <= pend_reg.price;
                report_quantity      <= {5'd0, pend_reg.qty};
                aggressor_status     <= pend_reg.agg;
                reject_reason        <= lom_pkg::RSN_NONE;
                resting_client_tag   <= pend_reg.rtag;
                resting_order_number <= pend_reg.rnum;
                resting_status       <= pend_reg.rstat;
                last_report          <= pend_reg.last || cmd.flush_last;
            end
            else
            begin
                report_price         <= ord_price_reg;
                resting_client_tag   <= '0;
                resting_order_number <= '0;
                resting_status       <= lom_pkg::RST_NONE;
                last_report          <= 1'b1;
                unique case (cmd.order_kind)
                    lom_pkg::ORD_NEW:
                    begin
                        report_quantity  <= ord_qty_reg;
                        aggressor_status <= lom_pkg::AGG_NEW;
                        reject_reason    <= lom_pkg::RSN_NONE;
                    end
                    lom_pkg::ORD_REJ_VALID:
                    begin
                        report_quantity  <= ord_qty_reg;
                        aggressor_status <= lom_pkg::AGG_REJECT;
                        reject_reason    <= reason;
                    end
                    default:
                    begin
                        report_quantity  <= {5'd0, rem_reg};
                        aggressor_status <= lom_pkg::AGG_REJECT;
                        reject_reason    <= lom_pkg::RSN_BOOK_FULL;
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;

    // Status to the controller.
    always_comb
    begin
        sts.out_free       = !out_valid_reg || !out_stall;
        sts.reason_nz      = (reason != lom_pkg::RSN_NONE);
        sts.qty_zero       = (ord_qty_reg == 16'd0);
        sts.scan_done      = !issue_more && !rdv_reg;
        sts.found          = found_reg;
        sts.crosses        = is_buy ? (best_reg.price <= ord_price_reg)
                                    : (best_reg.price >= ord_price_reg);
        sts.capped         = (n_reg >= 5'(lom_pkg::MAX_MATCHES));
        sts.rq_zero        = (rq == '0);
        sts.rem_after_zero = (rem_after == '0);
        sts.rem_zero       = (rem_reg == '0);
        sts.shift_done     = (ptr_plus >= cnt_sel);
        sts.own_full       = (cnt_sel >= CW'(BOOK_DEPTH));
        sts.pend_valid     = pend_valid_reg;
    end

    `LOM_ASSERT_IMP(a_push_free, push, (!out_valid_reg || !out_stall), "report pushed over a waiting report")
    `LOM_ASSERT_IMP(a_pend_held, cmd.push_pend, pend_valid_reg, "pending report flushed while empty")
    `LOM_ASSERT_IMP(a_match_cap, cmd.do_match, (n_reg < 5'(lom_pkg::MAX_MATCHES)), "match made beyond the cap")
    `LOM_ASSERT_IMP(a_one_source, cmd.push_pend, !cmd.push_order, "two report sources in one cycle")

endmodule

@@ sv/limit_order_matcher.sv @@
// Top level of the price-time-priority limit order matcher.
//
// Input channel: one limit order per item (in_valid, in_stall). in_stall is
// high while an order is being worked, so one order is processed at a time.
// Output channel: one report per item (out_valid, out_stall); an order gives
// one to thirty-two reports and the final one carries last_report.
// Configuration: cfg_we writes cfg_data into min_quantity (index 0) or
// max_quantity (index 1); write only while no order is in flight.
// Processing: a rejected order or a zero quantity order is reported straight
// from the check state. A matching order scans the whole opposite book for
// each match, and a removed resting entry moves each later entry up by one
// place, with a read and then a write. An order that only rests scans the
// opposite book once; each scan uses the single memory read port.
// Reset: all books empty, order numbers restart at one, registers return to
// ten and one thousand; there is no clearing pass.
// A stalled receiver freezes the report register and the matcher waits for
// it before pushing the next report; no report is lost.
module limit_order_matcher #(
    parameter int BOOK_DEPTH      = lom_pkg::BOOK_DEPTH_DEF,
    parameter int NUM_INSTRUMENTS = lom_pkg::NUM_INSTRUMENTS_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic                      cfg_index,
    input  logic [lom_pkg::QW-1:0]    cfg_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [31:0]               client_tag,
    input  logic [2:0]                instrument,
    input  logic [1:0]                side,
    input  logic signed [31:0]        limit_price,
    input  logic [15:0]               quantity,
    input  logic                      fields_complete,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [31:0]               client_tag_out,
    output logic [31:0]               order_number,
    output logic [2:0]                instrument_out,
    output logic [1:0]                side_out,
    output logic signed [31:0]        report_price,
    output logic [15:0]               report_quantity,
    output logic [1:0]                aggressor_status,
    output logic [2:0]                reject_reason,
    output logic [31:0]               resting_client_tag,
    output logic [31:0]               resting_order_number,
    output logic [1:0]                resting_status,
    output logic                      last_report
);

    lom_pkg::cmd_t cmd;
    lom_pkg::sts_t sts;
    logic          idle;

    // The controller only takes an order when it is idle.
    assign in_stall = !idle;

    lom_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sts      (sts),
        .cmd      (cmd),
        .idle     (idle)
    );

    lom_datapath #(
        .BOOK_DEPTH      (BOOK_DEPTH),
        .NUM_INSTRUMENTS (NUM_INSTRUMENTS)
    ) u_datapath (
        .clk                  (clk),
        .rst_n                (rst_n),
        .cmd                  (cmd),
        .sts                  (sts),
        .cfg_we               (cfg_we),
        .cfg_index            (cfg_index),
        .cfg_data             (cfg_data),
        .client_tag           (client_tag),
        .instrument           (instrument),
        .side                 (side),
        .limit_price          (limit_price),
        .quantity             (quantity),
        .fields_complete      (fields_complete),
        .out_stall            (out_stall),
        .out_valid            (out_valid),
        .client_tag_out       (client_tag_out),
        .order_number         (order_number),
        .instrument_out       (instrument_out),
        .side_out             (side_out),
        .report_price         (report_price),
        .report_quantity      (report_quantity),
        .aggressor_status     (aggressor_status),
        .reject_reason        (reject_reason),
        .resting_client_tag   (resting_client_tag),
        .resting_order_number (resting_order_number),
        .resting_status       (resting_status),
        .last_report          (last_report)
    );

endmodule
